### design/clp_pkg.sv
package clp_pkg;

   // coordinate word and derived widths
   localparam int CW   = 32;            // coordinate width
   localparam int DW   = CW + 1;        // signed difference
   localparam int PW   = 2 * CW + 1;    // signed product of two differences
   localparam int DOTW = 2 * CW + 3;    // signed dot sum
   localparam int DDW  = 2 * CW + 2;    // squared length, also dot magnitude
   localparam int CHK  = DDW / 2;       // dot magnitude chunk for the partial products
   localparam int NUMW = 3 * CW + 2;    // numerator magnitude
   localparam int QW   = CW + 1;        // kept quotient bits
   localparam int XW   = CW + 3;        // sum before clamping

   typedef logic [NUMW-1:0] num_type;
   typedef logic [QW-1:0]   quo_type;
   typedef logic [DDW-1:0]  len_type;

   typedef struct packed {
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic signed [CW-1:0] point_z;
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_z;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic                 degenerate;
      logic                 saturated;
   } rsp_type;

endpackage

### design/closest_point_on_line_top.sv
// Closest point on a 3D line. Each transaction carries a query point P and two line points
// A (start) and B (end) in signed fixed point; the result is X = A + D*(D.(P-A))/(D.D) with
// D = B-A, computed exactly and truncated toward zero, then clamped to the coordinate range
// (saturated flags a clamp). When A equals B the result is A with degenerate set. The block
// is fully pipelined and takes one transaction every cycle unless a stalled response holds it;
// a request passes through five arithmetic stages (differences, products, dot sums, partial
// products, numerator), 33 stages of the restoring divider (one quotient bit each, three lanes
// side by side) and the output register. A stalled response holds the whole pipeline in place.
module closest_point_on_line_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  clp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output clp_pkg::rsp_type rsp_data
);

   localparam int CW   = clp_pkg::CW;
   localparam int DW   = clp_pkg::DW;
   localparam int PW   = clp_pkg::PW;
   localparam int DOTW = clp_pkg::DOTW;
   localparam int DDW  = clp_pkg::DDW;
   localparam int CHK  = clp_pkg::CHK;
   localparam int NUMW = clp_pkg::NUMW;
   localparam int QW   = clp_pkg::QW;
   localparam int XW   = clp_pkg::XW;

   // coordinate bounds at the width of the unclamped sum
   localparam logic signed [XW-1:0] X_MAX = $signed({{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [XW-1:0] X_MIN = $signed({{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}});

   // response register
   logic             rsp_valid_ff;
   clp_pkg::rsp_type rsp_data_ff;

   // whole pipeline advances unless the response register is full and stalled
   logic adv;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // input fields as lanes
   logic signed [CW-1:0] in_p [3];
   logic signed [CW-1:0] in_a [3];
   logic signed [CW-1:0] in_b [3];
   assign in_p[0] = req_data.point_x;
   assign in_p[1] = req_data.point_y;
   assign in_p[2] = req_data.point_z;
   assign in_a[0] = req_data.start_x;
   assign in_a[1] = req_data.start_y;
   assign in_a[2] = req_data.start_z;
   assign in_b[0] = req_data.end_x;
   assign in_b[1] = req_data.end_y;
   assign in_b[2] = req_data.end_z;

   // stage 1: differences
   logic                 s1_v_ff;
   logic signed [DW-1:0] s1_d_ff  [3];
   logic signed [DW-1:0] s1_ap_ff [3];
   logic signed [CW-1:0] s1_a_ff  [3];

   // stage 2: products
   logic                   s2_v_ff;
   logic signed [PW-1:0]   s2_pd_ff  [3];
   logic [2*CW-1:0]        s2_sq_ff  [3];
   logic [CW-1:0]          s2_dm_ff  [3];
   logic                   s2_ds_ff  [3];
   logic signed [CW-1:0]   s2_a_ff   [3];
   logic                   s2_deg_ff;

   // stage 3: dot sums
   logic                   s3_v_ff;
   logic [DDW-1:0]         s3_dot_ff;
   clp_pkg::len_type       s3_dd_ff;
   logic [CW-1:0]          s3_dm_ff  [3];
   logic                   s3_neg_ff [3];
   logic signed [CW-1:0]   s3_a_ff   [3];
   logic                   s3_deg_ff;

   // stage 4: partial products
   logic                   s4_v_ff;
   logic [CW+CHK-1:0]      s4_lo_ff  [3];
   logic [CW+CHK-1:0]      s4_hi_ff  [3];
   clp_pkg::len_type       s4_dd_ff;
   logic                   s4_neg_ff [3];
   logic signed [CW-1:0]   s4_a_ff   [3];
   logic                   s4_deg_ff;

   // stage 5: numerator magnitude
   logic                   s5_v_ff;
   clp_pkg::num_type       s5_num_ff [3];
   clp_pkg::len_type       s5_dd_ff;
   logic                   s5_neg_ff [3];
   logic signed [CW-1:0]   s5_a_ff   [3];
   logic                   s5_deg_ff;

   // working signals for stages 2 to 3
   logic signed [2*DW-1:0] pd_full [3];
   logic [2*CW-1:0]        sq_full [3];
   logic signed [DOTW-1:0] dot_sum;
   logic [DDW-1:0]         dd_sum;
   logic [DOTW-1:0]        dot_abs;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd_full[i] = s1_d_ff[i] * s1_ap_ff[i];
      end
   end

   // |d| fits in CW bits: abs of a DW-bit difference of two CW-bit words
   logic [DW-1:0] d_abs [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_abs[i] = s1_d_ff[i][DW-1] ? DW'(-s1_d_ff[i]) : DW'(s1_d_ff[i]);
         sq_full[i] = d_abs[i][CW-1:0] * d_abs[i][CW-1:0];
      end
   end

   assign dot_sum = DOTW'(s2_pd_ff[0]) + DOTW'(s2_pd_ff[1]) + DOTW'(s2_pd_ff[2]);
   assign dd_sum  = DDW'(s2_sq_ff[0]) + DDW'(s2_sq_ff[1]) + DDW'(s2_sq_ff[2]);
   assign dot_abs = dot_sum[DOTW-1] ? DOTW'(-dot_sum) : DOTW'(dot_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            // stage 1
            s1_d_ff[i]  <= DW'(in_b[i]) - DW'(in_a[i]);
            s1_ap_ff[i] <= DW'(in_p[i]) - DW'(in_a[i]);
            s1_a_ff[i]  <= in_a[i];
            // stage 2
            s2_pd_ff[i] <= pd_full[i][PW-1:0];
            s2_sq_ff[i] <= sq_full[i];
            s2_dm_ff[i] <= d_abs[i][CW-1:0];
            s2_ds_ff[i] <= s1_d_ff[i][DW-1];
            s2_a_ff[i]  <= s1_a_ff[i];
            // stage 3
            s3_dm_ff[i]  <= s2_dm_ff[i];
            s3_neg_ff[i] <= s2_ds_ff[i] ^ dot_sum[DOTW-1];
            s3_a_ff[i]   <= s2_a_ff[i];
            // stage 4
            s4_lo_ff[i]  <= s3_dm_ff[i] * s3_dot_ff[CHK-1:0];
            s4_hi_ff[i]  <= s3_dm_ff[i] * s3_dot_ff[2*CHK-1:CHK];
            s4_neg_ff[i] <= s3_neg_ff[i];
            s4_a_ff[i]   <= s3_a_ff[i];
            // stage 5
            s5_num_ff[i] <= NUMW'(s4_lo_ff[i]) + (NUMW'(s4_hi_ff[i]) << CHK);
            s5_neg_ff[i] <= s4_neg_ff[i];
            s5_a_ff[i]   <= s4_a_ff[i];
         end
         s2_deg_ff <= (s1_d_ff[0] == '0) && (s1_d_ff[1] == '0) && (s1_d_ff[2] == '0);
         s3_dot_ff <= dot_abs[DDW-1:0];
         s3_dd_ff  <= dd_sum;
         s3_deg_ff <= s2_deg_ff;
         s4_dd_ff  <= s3_dd_ff;
         s4_deg_ff <= s3_deg_ff;
         s5_dd_ff  <= s4_dd_ff;
         s5_deg_ff <= s4_deg_ff;
      end
   end

   // divider: stage j resolves quotient bit QW-1-j in all three lanes
   clp_pkg::num_type     rem_w [3][QW+1];
   clp_pkg::quo_type     quo_w [3][QW+1];
   logic                 dv_ff   [QW];
   clp_pkg::len_type     ddd_ff  [QW];
   logic                 ddeg_ff [QW];
   logic                 dneg_ff [QW][3];
   logic                 dbig_ff [QW][3];
   logic signed [CW-1:0] da_ff   [QW][3];

   // quotient at least 2^QW: result lands outside the range whatever the low bits
   logic big_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         big_in[i] = {1'b0, s5_num_ff[i]} >= ({{(NUMW + 1 - DDW){1'b0}}, s5_dd_ff} << QW);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign rem_w[i][0] = s5_num_ff[i];
      assign quo_w[i][0] = '0;
      for (genvar j = 0; j < QW; j++) begin : g_step
         clp_div_step #(
            .SHIFT (QW - 1 - j)
         ) u_step (
            .clock   (clock),
            .enable  (adv),
            .rem_in  (rem_w[i][j]),
            .quo_in  (quo_w[i][j]),
            .divisor ((j == 0) ? s5_dd_ff : ddd_ff[(j == 0) ? 0 : j - 1]),
            .rem_out (rem_w[i][j+1]),
            .quo_out (quo_w[i][j+1])
         );
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_side
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_ff[j] <= s5_v_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               ddd_ff[j]  <= s5_dd_ff;
               ddeg_ff[j] <= s5_deg_ff;
               for (int i = 0; i < 3; i++) begin
                  dneg_ff[j][i] <= s5_neg_ff[i];
                  dbig_ff[j][i] <= big_in[i];
                  da_ff[j][i]   <= s5_a_ff[i];
               end
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_ff[j] <= 1'b0;
            end else if (adv) begin
               dv_ff[j] <= dv_ff[j-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               ddd_ff[j]  <= ddd_ff[j-1];
               ddeg_ff[j] <= ddeg_ff[j-1];
               for (int i = 0; i < 3; i++) begin
                  dneg_ff[j][i] <= dneg_ff[j-1][i];
                  dbig_ff[j][i] <= dbig_ff[j-1][i];
                  da_ff[j][i]   <= da_ff[j-1][i];
               end
            end
         end
      end
   end

   // final add of the start point and clamp
   logic signed [XW-1:0] sum_x [3];
   logic signed [CW-1:0] clamp_x [3];
   logic                 clamp_hit [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [QW-1:0] mag;
         mag = dbig_ff[QW-1][i] ? '1 : quo_w[i][QW];
         sum_x[i] = dneg_ff[QW-1][i] ? (XW'(da_ff[QW-1][i]) - XW'({1'b0, mag}))
                                      : (XW'(da_ff[QW-1][i]) + XW'({1'b0, mag}));
         clamp_hit[i] = 1'b0;
         clamp_x[i]   = sum_x[i][CW-1:0];
         if (sum_x[i] > X_MAX) begin
            clamp_x[i]   = {1'b0, {(CW-1){1'b1}}};
            clamp_hit[i] = 1'b1;
         end else if (sum_x[i] < X_MIN) begin
            clamp_x[i]   = {1'b1, {(CW-1){1'b0}}};
            clamp_hit[i] = 1'b1;
         end
         if (ddeg_ff[QW-1]) begin
            clamp_x[i]   = da_ff[QW-1][i];
            clamp_hit[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.near_x     <= clamp_x[0];
         rsp_data_ff.near_y     <= clamp_x[1];
         rsp_data_ff.near_z     <= clamp_x[2];
         rsp_data_ff.degenerate <= ddeg_ff[QW-1];
         rsp_data_ff.saturated  <= clamp_hit[0] | clamp_hit[1] | clamp_hit[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a degenerate line never clamps
   a_deg_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.degenerate && rsp_data.saturated))
      else $error("degenerate response marked saturated");

   // a clamp leaves at least one coordinate on a bound
   a_sat_on_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.near_x == {1'b0, {(CW-1){1'b1}}} || rsp_data.near_x == {1'b1, {(CW-1){1'b0}}} ||
          rsp_data.near_y == {1'b0, {(CW-1){1'b1}}} || rsp_data.near_y == {1'b1, {(CW-1){1'b0}}} ||
          rsp_data.near_z == {1'b0, {(CW-1){1'b1}}} || rsp_data.near_z == {1'b1, {(CW-1){1'b0}}}))
      else $error("saturated response with no coordinate on a bound");

   // an accepted transaction enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_v_ff)
      else $error("accepted transaction missing from first stage");

   // a stalled response freezes the divider tail
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(dv_ff[QW-1]) && $stable(ddeg_ff[QW-1]))
      else $error("pipeline moved during a stall");

endmodule

### design/clp_div_step.sv
module clp_div_step #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              enable,
   input  clp_pkg::num_type  rem_in,
   input  clp_pkg::quo_type  quo_in,
   input  clp_pkg::len_type  divisor,
   output clp_pkg::num_type  rem_out,
   output clp_pkg::quo_type  quo_out
);

   logic [clp_pkg::NUMW:0]   shifted;
   logic [clp_pkg::NUMW:0]   trial;
   clp_pkg::num_type         rem_ff, rem_next_in;
   clp_pkg::quo_type         quo_ff, quo_next_in;

   // one restoring step against the divisor shifted to this quotient bit
   assign shifted = {{(clp_pkg::NUMW + 1 - clp_pkg::DDW){1'b0}}, divisor} << SHIFT;
   assign trial   = {1'b0, rem_in} - shifted;

   always_comb begin
      rem_next_in = rem_in;
      quo_next_in = quo_in;
      if (!trial[clp_pkg::NUMW]) begin
         rem_next_in         = trial[clp_pkg::NUMW-1:0];
         quo_next_in[SHIFT]  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_next_in;
         quo_ff <= quo_next_in;
      end
   end

   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule
